@@ rtl/core/iswf_pkg.sv @@
// Shared types and constants of the scale weight filter.
`default_nettype none

package iswf_pkg;

    // Field and register widths fixed by the block's interface.
    localparam int COEF_W      = 16;
    localparam int VALUE_W     = 16;
    localparam int GRAMS_W     = 15;
    localparam int HOLD_W      = 10;
    localparam int REG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int M_TDATA_W   = 32;

    // Products summed by the serial multiply-accumulate: three folded numerator
    // taps followed by four feedback taps.
    localparam int NUM_TERMS   = 7;

    // Upper accumulator part of the serial MAC; the lower part is shifted out.
    localparam int ACC_HI_W    = COEF_W + 5;

    localparam int VALUE_MAX   = 32767;
    localparam int VALUE_MIN   = -32768;

    // Reset values of the configuration registers.
    localparam logic signed [COEF_W-1:0] NUM_OUTER_RST  = 16'sd2027;
    localparam logic signed [COEF_W-1:0] NUM_INNER_RST  = 16'sd8108;
    localparam logic signed [COEF_W-1:0] NUM_CENTER_RST = 16'sd12162;
    localparam logic signed [COEF_W-1:0] FB_ONE_RST     = -16'sd5843;
    localparam logic signed [COEF_W-1:0] FB_TWO_RST     = -16'sd8621;
    localparam logic signed [COEF_W-1:0] FB_THREE_RST   = -16'sd1254;
    localparam logic signed [COEF_W-1:0] FB_FOUR_RST    = -16'sd330;
    localparam logic [HOLD_W-1:0]        HOLD_BAND_RST  = 10'd25;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUM_OUTER  = 3'd0,
        REG_NUM_INNER  = 3'd1,
        REG_NUM_CENTER = 3'd2,
        REG_FB_ONE     = 3'd3,
        REG_FB_TWO     = 3'd4,
        REG_FB_THREE   = 3'd5,
        REG_FB_FOUR    = 3'd6,
        REG_HOLD_BAND  = 3'd7
    } reg_index_t;

    // Grams scaling: grams = round(v * 30000 / (2046 * F)).
    localparam int GRAMS_SCALE     = 30000;
    localparam int GRAMS_DIV       = 2046;
    localparam int GRAMS_HALF      = 1023;
    localparam int GRAMS_MAX       = 32767;
    localparam int GRAMS_SAT_LIMIT = (GRAMS_MAX + 1) * GRAMS_DIV;
    localparam int DIV_IN_W        = 26;
    localparam int RECIP_SHIFT     = 37;
    localparam int RECIP_W         = 27;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(GRAMS_DIV - 1)) / 64'(GRAMS_DIV);
    localparam logic [RECIP_W-1:0] GRAMS_RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] filtered;
        logic [GRAMS_W-1:0]        grams;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/iswf_serial_mac.sv @@
// Bit-serial multiply-accumulate over the seven filter products.
`default_nettype none

module iswf_serial_mac #(
    parameter int DATA_W = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic signed [DATA_W-1:0]                  data_in [iswf_pkg::NUM_TERMS],
    input  logic signed [iswf_pkg::COEF_W-1:0]        coef    [iswf_pkg::NUM_TERMS],
    output logic                                      done,
    output logic signed [iswf_pkg::ACC_HI_W-1:0]      acc_hi,
    output logic [DATA_W-1:0]                         acc_lo
);

    localparam int CNT_W  = $clog2(DATA_W);
    localparam int PART_W = iswf_pkg::COEF_W + 4;
    localparam int HI_W   = iswf_pkg::ACC_HI_W;

    logic [DATA_W-1:0]        data_sr_reg [iswf_pkg::NUM_TERMS];
    logic signed [HI_W-1:0]   hi_reg;
    logic [DATA_W-1:0]        lo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic                     last_bit;
    logic signed [PART_W-1:0] term;
    logic signed [PART_W-1:0] partial;
    logic signed [HI_W:0]     sum;

    assign last_bit = (cnt_reg == CNT_W'(DATA_W - 1));

    // The data words go LSB first; the sign bit carries negative weight.
    always_comb begin
        partial = '0;
        term    = '0;
        for (int j = 0; j < iswf_pkg::NUM_TERMS; j++) begin
            term = PART_W'(coef[j]);
            if (data_sr_reg[j][0]) begin
                partial = last_bit ? partial - term : partial + term;
            end
        end
    end

    assign sum = (HI_W + 1)'(hi_reg) + (HI_W + 1)'(partial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                hi_reg   <= '0;
                lo_reg   <= '0;
                for (int j = 0; j < iswf_pkg::NUM_TERMS; j++) begin
                    data_sr_reg[j] <= data_in[j];
                end
            end else if (busy_reg) begin
                for (int j = 0; j < iswf_pkg::NUM_TERMS; j++) begin
                    data_sr_reg[j] <= data_sr_reg[j] >> 1;
                end
                lo_reg  <= {sum[0], lo_reg[DATA_W-1:1]};
                hi_reg  <= sum[HI_W:1];
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_bit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign acc_hi = hi_reg;
    assign acc_lo = lo_reg;

endmodule

`default_nettype wire

@@ rtl/core/iswf_weight.sv @@
// Rounding, saturation, piecewise grams scaling and hold band.
`default_nettype none

module iswf_weight #(
    parameter int ACC_W           = 37,
    parameter int COEF_FRAC_BITS  = 14,
    parameter int VALUE_FRAC_BITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              acc_valid,
    input  logic signed [ACC_W-1:0]           acc,
    input  logic [iswf_pkg::HOLD_W-1:0]       hold_band,
    output iswf_pkg::result_t                 result
);

    localparam int RND_W  = ACC_W + 1;
    localparam int D_W    = 20;
    localparam int DX_W   = D_W + 4;
    localparam int V_W    = 17;
    localparam int PROD_W = 32;
    localparam int MUL_W  = iswf_pkg::DIV_IN_W + iswf_pkg::RECIP_W;
    localparam int G_W    = iswf_pkg::GRAMS_W;
    localparam int F_VAL  = 1 << VALUE_FRAC_BITS;

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] Y_MAX    = RND_W'(iswf_pkg::VALUE_MAX);
    localparam logic signed [RND_W-1:0] Y_MIN    = RND_W'(iswf_pkg::VALUE_MIN);

    // Stage 1: round half up and saturate.
    logic signed [RND_W-1:0]              rnd;
    logic signed [RND_W-1:0]              shifted;
    logic signed [iswf_pkg::VALUE_W-1:0]  y1_next;
    logic signed [iswf_pkg::VALUE_W-1:0]  y1_reg;
    logic                                 v1_reg;

    assign rnd     = RND_W'(acc) + RND_HALF;
    assign shifted = rnd >>> COEF_FRAC_BITS;

    always_comb begin
        if (shifted > Y_MAX) begin
            y1_next = iswf_pkg::VALUE_W'(iswf_pkg::VALUE_MAX);
        end else if (shifted < Y_MIN) begin
            y1_next = iswf_pkg::VALUE_W'(iswf_pkg::VALUE_MIN);
        end else begin
            y1_next = shifted[iswf_pkg::VALUE_W-1:0];
        end
    end

    // Stage 2: remove the 9.5 count offset and double, force small values to zero, pick the segment, scale by 30000.
    logic signed [D_W-1:0]   d2;
    logic signed [DX_W-1:0]  d2x10;
    logic                    zero2_next;
    logic signed [D_W-1:0]   off_add;
    logic signed [D_W-1:0]   v_full;
    logic [V_W-1:0]          v_u;
    logic [PROD_W-1:0]       prod2_next;
    logic [PROD_W-1:0]       prod2_reg;
    logic                    zero2_reg;
    logic signed [iswf_pkg::VALUE_W-1:0] y2_reg;
    logic                    v2_reg;

    assign d2         = (D_W'(y1_reg) <<< 1) - D_W'(19 * F_VAL);
    assign d2x10      = DX_W'(d2) * DX_W'(10);
    assign zero2_next = (d2x10 <= DX_W'(2 * F_VAL));

    always_comb begin
        if (d2 < D_W'(60 * F_VAL)) begin
            off_add = D_W'(4 * F_VAL);
        end else if (d2 > D_W'(200 * F_VAL)) begin
            off_add = D_W'(20 * F_VAL);
        end else begin
            off_add = D_W'(10 * F_VAL);
        end
    end

    assign v_full     = d2 + off_add;
    assign v_u        = zero2_next ? '0 : v_full[V_W-1:0];
    assign prod2_next = PROD_W'(v_u) * PROD_W'(iswf_pkg::GRAMS_SCALE);

    // Stage 3: divide by 2046*F through the fraction shift and a reciprocal.
    logic [PROD_W-1:0]  np;
    logic               sat3_next;
    logic [MUL_W-1:0]   mul3_next;
    logic [MUL_W-1:0]   mul3_reg;
    logic               sat3_reg;
    logic               zero3_reg;
    logic signed [iswf_pkg::VALUE_W-1:0] y3_reg;
    logic               v3_reg;

    assign np        = (prod2_reg >> VALUE_FRAC_BITS) + PROD_W'(iswf_pkg::GRAMS_HALF);
    assign sat3_next = (np >= PROD_W'(iswf_pkg::GRAMS_SAT_LIMIT));
    assign mul3_next = MUL_W'(np[iswf_pkg::DIV_IN_W-1:0]) * MUL_W'(iswf_pkg::GRAMS_RECIP);

    // Stage 4: saturate grams and apply the hold band.
    logic [G_W-1:0]  grams_raw;
    logic [G_W:0]    last_plus;
    logic [G_W:0]    grams_plus;
    logic            keep;
    logic [G_W-1:0]  grams_final;
    logic [G_W-1:0]  last_weight_reg;
    iswf_pkg::result_t result_reg;

    always_comb begin
        if (zero3_reg) begin
            grams_raw = '0;
        end else if (sat3_reg) begin
            grams_raw = G_W'(iswf_pkg::GRAMS_MAX);
        end else begin
            grams_raw = mul3_reg[iswf_pkg::RECIP_SHIFT+G_W-1:iswf_pkg::RECIP_SHIFT];
        end
    end

    assign last_plus   = (G_W + 1)'(last_weight_reg) + (G_W + 1)'(hold_band);
    assign grams_plus  = (G_W + 1)'(grams_raw) + (G_W + 1)'(hold_band);
    assign keep        = ((G_W + 1)'(grams_raw) < last_plus) &&
                         (grams_plus > (G_W + 1)'(last_weight_reg));
    assign grams_final = keep ? last_weight_reg : grams_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            result_reg.valid <= 1'b0;
            last_weight_reg  <= '0;
        end else begin
            v1_reg           <= acc_valid;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            result_reg.valid <= v3_reg;
            if (acc_valid) begin
                y1_reg <= y1_next;
            end
            if (v1_reg) begin
                prod2_reg <= prod2_next;
                zero2_reg <= zero2_next;
                y2_reg    <= y1_reg;
            end
            if (v2_reg) begin
                mul3_reg  <= mul3_next;
                sat3_reg  <= sat3_next;
                zero3_reg <= zero2_reg;
                y3_reg    <= y2_reg;
            end
            if (v3_reg) begin
                result_reg.filtered <= y3_reg;
                result_reg.grams    <= grams_final;
                last_weight_reg     <= grams_final;
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ rtl/core/iir_scale_weight_filter_unit.sv @@
// Top level of the load-cell IIR filter and weight readout.
//
// Usage: each item on the slave stream (s_tvalid/s_tready/s_tdata) carries one
// unsigned converter sample. For every item the block returns one item on the
// master stream holding the filtered value in 1/16 counts and the held weight
// in grams. The filter is a fourth-order direct form I low-pass whose seven
// products (three folded numerator taps, four feedback taps) are summed by a
// bit-serial multiply-accumulate, one data bit per cycle. A four-stage
// pipeline then rounds, saturates and converts to grams. An item can be
// accepted in the cycle after the previous result is loaded into the output
// register; no new item is taken while one is in the MAC or the pipeline
// or while its result waits to be loaded.
// The output register separates the two sides: a new item may be accepted while
// the last result waits for m_tready. If the receiver still holds the previous
// result when a new one is ready, the block waits until that result is taken.
// Reset clears the filter histories and the held weight and restores the
// default coefficients and hold band. Registers are written through the
// cfg_wr_en/cfg_index/cfg_wr_data port; the user must do so only while no item
// is in flight, as the block itself does not enforce it.
`default_nettype none

module iir_scale_weight_filter_unit #(
    parameter int SAMPLE_BITS     = 10,
    parameter int COEF_FRAC_BITS  = 14,
    parameter int VALUE_FRAC_BITS = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Bits from the lowest: adc_sample, then zero fill.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Bits from the lowest: filtered_value [15:0], weight_grams [30:16], zero.
    output logic [iswf_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [iswf_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [iswf_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    // The numerator operands carry the value fraction and a sign bit; the
    // serial word must also hold a full filtered value.
    localparam int NUM_OPND_W = SAMPLE_BITS + 2 + VALUE_FRAC_BITS;
    localparam int MAC_W      = (NUM_OPND_W > iswf_pkg::VALUE_W) ?
                                NUM_OPND_W : iswf_pkg::VALUE_W;
    localparam int ACC_W      = iswf_pkg::ACC_HI_W + MAC_W;
    localparam int CW         = iswf_pkg::COEF_W;
    localparam int VW         = iswf_pkg::VALUE_W;
    localparam int TAPS       = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic signed [CW-1:0]              num_outer_reg;
    logic signed [CW-1:0]              num_inner_reg;
    logic signed [CW-1:0]              num_center_reg;
    logic signed [CW-1:0]              fb_one_reg;
    logic signed [CW-1:0]              fb_two_reg;
    logic signed [CW-1:0]              fb_three_reg;
    logic signed [CW-1:0]              fb_four_reg;
    logic [iswf_pkg::HOLD_W-1:0]       hold_band_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_outer_reg  <= iswf_pkg::NUM_OUTER_RST;
            num_inner_reg  <= iswf_pkg::NUM_INNER_RST;
            num_center_reg <= iswf_pkg::NUM_CENTER_RST;
            fb_one_reg     <= iswf_pkg::FB_ONE_RST;
            fb_two_reg     <= iswf_pkg::FB_TWO_RST;
            fb_three_reg   <= iswf_pkg::FB_THREE_RST;
            fb_four_reg    <= iswf_pkg::FB_FOUR_RST;
            hold_band_reg  <= iswf_pkg::HOLD_BAND_RST;
        end else if (cfg_wr_en) begin
            unique case (iswf_pkg::reg_index_t'(cfg_index))
                iswf_pkg::REG_NUM_OUTER:  num_outer_reg  <= cfg_wr_data;
                iswf_pkg::REG_NUM_INNER:  num_inner_reg  <= cfg_wr_data;
                iswf_pkg::REG_NUM_CENTER: num_center_reg <= cfg_wr_data;
                iswf_pkg::REG_FB_ONE:     fb_one_reg     <= cfg_wr_data;
                iswf_pkg::REG_FB_TWO:     fb_two_reg     <= cfg_wr_data;
                iswf_pkg::REG_FB_THREE:   fb_three_reg   <= cfg_wr_data;
                iswf_pkg::REG_FB_FOUR:    fb_four_reg    <= cfg_wr_data;
                iswf_pkg::REG_HOLD_BAND:
                    hold_band_reg <= cfg_wr_data[iswf_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and the output register.
    state_t                         state_reg;
    logic                           m_tvalid_reg;
    logic [iswf_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           in_accept;
    logic                           out_free;
    iswf_pkg::result_t              result;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // While a result waits to be loaded, the load below owns m_tvalid.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (result.valid) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, result.grams, result.filtered};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Filter histories, newest first.
    logic [SAMPLE_BITS-1:0] in_hist_reg  [TAPS];
    logic signed [VW-1:0]   out_hist_reg [TAPS];
    logic [SAMPLE_BITS-1:0] sample;

    assign sample = s_tdata[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                for (int i = TAPS - 1; i > 0; i--) begin
                    in_hist_reg[i] <= in_hist_reg[i-1];
                end
                in_hist_reg[0] <= sample;
            end
            if (result.valid) begin
                for (int i = TAPS - 1; i > 0; i--) begin
                    out_hist_reg[i] <= out_hist_reg[i-1];
                end
                out_hist_reg[0] <= result.filtered;
            end
        end
    end

    // Operands of the serial MAC. The symmetric numerator is folded so that
    // equal coefficients share one product; the numerator side is scaled up by
    // the value fraction before it meets the feedback side.
    logic [SAMPLE_BITS:0]          sum_outer;
    logic [SAMPLE_BITS:0]          sum_inner;
    logic signed [MAC_W-1:0]       mac_data [iswf_pkg::NUM_TERMS];
    logic signed [CW-1:0]          mac_coef [iswf_pkg::NUM_TERMS];

    assign sum_outer = (SAMPLE_BITS + 1)'(sample) + (SAMPLE_BITS + 1)'(in_hist_reg[3]);
    assign sum_inner = (SAMPLE_BITS + 1)'(in_hist_reg[0]) + (SAMPLE_BITS + 1)'(in_hist_reg[2]);

    assign mac_data[0] = MAC_W'(sum_outer) << VALUE_FRAC_BITS;
    assign mac_data[1] = MAC_W'(sum_inner) << VALUE_FRAC_BITS;
    assign mac_data[2] = MAC_W'(in_hist_reg[1]) << VALUE_FRAC_BITS;
    assign mac_data[3] = MAC_W'(out_hist_reg[0]);
    assign mac_data[4] = MAC_W'(out_hist_reg[1]);
    assign mac_data[5] = MAC_W'(out_hist_reg[2]);
    assign mac_data[6] = MAC_W'(out_hist_reg[3]);

    assign mac_coef[0] = num_outer_reg;
    assign mac_coef[1] = num_inner_reg;
    assign mac_coef[2] = num_center_reg;
    assign mac_coef[3] = fb_one_reg;
    assign mac_coef[4] = fb_two_reg;
    assign mac_coef[5] = fb_three_reg;
    assign mac_coef[6] = fb_four_reg;

    logic                                  mac_done;
    logic signed [iswf_pkg::ACC_HI_W-1:0]  mac_acc_hi;
    logic [MAC_W-1:0]                      mac_acc_lo;
    logic signed [ACC_W-1:0]               mac_acc;

    iswf_serial_mac #(
        .DATA_W (MAC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_accept),
        .data_in (mac_data),
        .coef    (mac_coef),
        .done    (mac_done),
        .acc_hi  (mac_acc_hi),
        .acc_lo  (mac_acc_lo)
    );

    assign mac_acc = {mac_acc_hi, mac_acc_lo};

    iswf_weight #(
        .ACC_W           (ACC_W),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_valid (mac_done),
        .acc       (mac_acc),
        .hold_band (hold_band_reg),
        .result    (result)
    );

endmodule

`default_nettype wire
